>>> src/oau_pkg.sv
package oau_pkg;

    localparam int RAM_DEPTH_DEFAULT = 65536;
    localparam int LIMIT_W           = 17;
    localparam logic [LIMIT_W-1:0] RAM_LIMIT_RESET = 17'd49152;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [15:0] ZP_MASK = 16'h00ff;

    localparam logic [3:0] MODE_ZPG  = 4'd0;
    localparam logic [3:0] MODE_ZPGX = 4'd1;
    localparam logic [3:0] MODE_ZPGY = 4'd2;
    localparam logic [3:0] MODE_ABS  = 4'd3;
    localparam logic [3:0] MODE_ABSX = 4'd4;
    localparam logic [3:0] MODE_ABSY = 4'd5;
    localparam logic [3:0] MODE_IND  = 4'd6;
    localparam logic [3:0] MODE_INDX = 4'd7;
    localparam logic [3:0] MODE_INDY = 4'd8;

    localparam int CMD_WRITE_BIT = 0;
    localparam int CMD_WORD_BIT  = 1;

endpackage

>>> src/oau_ram.sv
module oau_ram #(
    parameter int DEPTH = oau_pkg::RAM_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    import oau_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/cpu6502_operand_address_unit.sv
// 6502 operand address unit.
// The s_ channel carries one memory access per beat: a byte read or write in one of the
// nine 6502 addressing modes, or a little-endian word read or write at an absolute address.
// The m_ channel returns one beat per access with the effective address, the read data and
// a flag per byte that went to the external bus instead of internal RAM.
// The cfg channel writes the RAM limit and is always ready; the user must write it only while idle (not enforced).
// Each access runs on a single-port RAM with a registered read and one shared 16-bit adder
// under a small sequencer; the RAM port sets the timing. A direct byte access steps
// through S_ACC0 and S_FIN, a word access through S_ACC0, S_ACC1 and S_FIN, and an
// indirect byte access first reads the two pointer bytes in S_PLO, S_PHI and S_PWAIT.
// s_tready returns in the same cycle that m_tvalid rises. One access is in flight at a time.
// After reset the block clears the RAM one byte per cycle, every address up to RAM_DEPTH-1,
// with s_tready low; configuration writes are taken meanwhile.
// The result sits in an output register, so a new beat is accepted while the previous
// result still waits; if the receiver stalls, the next result is held in the sequencer,
// with s_tready low, until the output register frees up.
module cpu6502_operand_address_unit #(
    parameter int RAM_DEPTH = oau_pkg::RAM_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cmd, mode, operand_address, index_x, index_y, write_data, zero fill
    input  logic [oau_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // effective_address, read_data, external_bytes, zero fill
    output logic [oau_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [oau_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import oau_pkg::*;

    localparam int AW = $clog2(RAM_DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PLO   = 3'd2;
    localparam logic [2:0] S_PHI   = 3'd3;
    localparam logic [2:0] S_PWAIT = 3'd4;
    localparam logic [2:0] S_ACC0  = 3'd5;
    localparam logic [2:0] S_ACC1  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [LIMIT_W-1:0]   ram_limit_reg;
    logic [1:0]           cmd_reg, cmd_next;
    logic [3:0]           mode_reg, mode_next;
    logic [7:0]           y_reg, y_next;
    logic [15:0]          wd_reg, wd_next;
    logic [15:0]          ea_reg, ea_next;
    logic [15:0]          addr1_reg, addr1_next;
    logic [7:0]           ptr_reg, ptr_next;
    logic [7:0]           lo_reg, lo_next;
    logic                 int0_reg, int0_next;
    logic                 int1_reg, int1_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [15:0]          add_a, add_b, sum;
    logic                 ram_en, ram_we;
    logic [AW-1:0]        ram_addr;
    logic [7:0]           ram_wdata, ram_rdata;
    logic                 int_ea, int_a1;
    logic                 out_load;
    logic [15:0]          out_rd;
    logic [1:0]           out_ext;

    logic [1:0]           in_cmd;
    logic [3:0]           in_mode;
    logic [15:0]          in_op;
    logic [7:0]           in_x, in_y;
    logic [15:0]          in_wd;
    logic                 in_word, is_wr, is_word;

    assign in_cmd  = s_tdata[1:0];
    assign in_mode = s_tdata[5:2];
    assign in_op   = s_tdata[21:6];
    assign in_x    = s_tdata[29:22];
    assign in_y    = s_tdata[37:30];
    assign in_wd   = s_tdata[53:38];
    assign in_word = in_cmd[CMD_WORD_BIT];
    assign is_wr   = cmd_reg[CMD_WRITE_BIT];
    assign is_word = cmd_reg[CMD_WORD_BIT];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;

    assign sum = add_a + add_b;

    assign int_ea = ({1'b0, ea_reg} < ram_limit_reg)
                 && ({1'b0, ea_reg} < LIMIT_W'(RAM_DEPTH));
    assign int_a1 = ({1'b0, addr1_reg} < ram_limit_reg)
                 && ({1'b0, addr1_reg} < LIMIT_W'(RAM_DEPTH));

    oau_ram #(
        .DEPTH (RAM_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cmd_next      = cmd_reg;
        mode_next     = mode_reg;
        y_next        = y_reg;
        wd_next       = wd_reg;
        ea_next       = ea_reg;
        addr1_next    = addr1_reg;
        ptr_next      = ptr_reg;
        lo_next       = lo_reg;
        int0_next     = int0_reg;
        int1_next     = int1_reg;
        m_tdata_next  = m_tdata_reg;
        add_a         = 16'h0000;
        add_b         = 16'h0000;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = '0;
        ram_wdata     = 8'h00;
        out_load      = 1'b0;
        out_rd        = 16'h0000;
        out_ext       = 2'b00;

        case (state_reg)
            S_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(RAM_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                add_a = in_op;
                if (!in_word && (in_mode inside {MODE_ZPGX, MODE_ABSX, MODE_INDX})) begin
                    add_b = {8'h00, in_x};
                end else if (!in_word && (in_mode inside {MODE_ZPGY, MODE_ABSY})) begin
                    add_b = {8'h00, in_y};
                end
                if (s_tvalid) begin
                    cmd_next  = in_cmd;
                    mode_next = in_mode;
                    y_next    = in_y;
                    wd_next   = in_wd;
                    ptr_next  = sum[7:0];
                    if (!in_word && (in_mode inside {MODE_ZPG, MODE_ZPGX, MODE_ZPGY})) begin
                        ea_next = sum & ZP_MASK;
                    end else begin
                        ea_next = sum;
                    end
                    if (!in_word && (in_mode inside {MODE_IND, MODE_INDX, MODE_INDY})) begin
                        state_next = S_PLO;
                    end else begin
                        state_next = S_ACC0;
                    end
                end
            end
            S_PLO: begin
                ram_en     = 1'b1;
                ram_addr   = AW'(ptr_reg);
                state_next = S_PHI;
            end
            S_PHI: begin
                add_a      = {8'h00, ptr_reg};
                add_b      = 16'h0001;
                ram_en     = 1'b1;
                ram_addr   = AW'(sum[7:0]);
                lo_next    = ram_rdata;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                add_a = {ram_rdata, lo_reg};
                if (mode_reg == MODE_INDY) begin
                    add_b = {8'h00, y_reg};
                end
                ea_next    = sum;
                state_next = S_ACC0;
            end
            S_ACC0: begin
                add_a      = ea_reg;
                add_b      = 16'h0001;
                addr1_next = sum;
                int0_next  = int_ea;
                ram_en     = int_ea;
                ram_we     = int_ea && is_wr;
                ram_addr   = AW'(ea_reg);
                ram_wdata  = wd_reg[7:0];
                state_next = is_word ? S_ACC1 : S_FIN;
            end
            S_ACC1: begin
                lo_next    = (int0_reg && !is_wr) ? ram_rdata : 8'h00;
                int1_next  = int_a1;
                ram_en     = int_a1;
                ram_we     = int_a1 && is_wr;
                ram_addr   = AW'(addr1_reg);
                ram_wdata  = wd_reg[15:8];
                state_next = S_FIN;
            end
            S_FIN: begin
                if (is_word) begin
                    out_rd  = {(int1_reg && !is_wr) ? ram_rdata : 8'h00, lo_reg};
                    out_ext = {!int1_reg, !int0_reg};
                end else begin
                    out_rd  = {8'h00, (int0_reg && !is_wr) ? ram_rdata : 8'h00};
                    out_ext = {1'b0, !int0_reg};
                end
                if (!m_tvalid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_tdata_next = {6'b000000, out_ext, out_rd, ea_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            ram_limit_reg <= RAM_LIMIT_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                ram_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        mode_reg    <= mode_next;
        y_reg       <= y_next;
        wd_reg      <= wd_next;
        ea_reg      <= ea_next;
        addr1_reg   <= addr1_next;
        ptr_reg     <= ptr_next;
        lo_reg      <= lo_next;
        int0_reg    <= int0_next;
        int1_reg    <= int1_next;
        m_tdata_reg <= m_tdata_next;
    end

    // A RAM write outside the clearing pass only ever lands on an internal address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_CLEAR)
        |-> ((state_reg == S_ACC0 && int_ea) || (state_reg == S_ACC1 && int_a1)))
        else $error("RAM write to an external address");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE && state_reg != S_CLEAR))
        else $error("accepted beat was not started");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result appeared outside the final step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !is_word) |-> (out_ext[1] == 1'b0 && out_rd[15:8] == 8'h00))
        else $error("byte access produced high byte status");

endmodule

>>> sim/oau_access_checker.sv
`timescale 1ns / 100ps

module oau_access_checker #(
    parameter int RAM_DEPTH = oau_pkg::RAM_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [oau_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [oau_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [oau_pkg::LIMIT_W-1:0]     cfg_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    output int                              outstanding,
    output int                              results_checked,
    output int                              fail_count
);
    import oau_pkg::*;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] data;
        logic [1:0]  ext_mask;
    } access_t;

    logic [7:0]         mem_image [0:RAM_DEPTH-1];
    logic [LIMIT_W-1:0] ram_limit_q;
    access_t            pending_q [$];
    int                 checked = 0;
    int                 fails = 0;

    // Returns {external, byte}; internal writes update the RAM image.
    function automatic logic [8:0] touch_byte(input logic [15:0] a, input logic wr,
                                              input logic [7:0] v);
        if (!({1'b0, a} < ram_limit_q && int'(a) < RAM_DEPTH))
            return {1'b1, 8'h00};
        if (wr) begin
            mem_image[a] = v;
            return 9'h000;
        end
        return {1'b0, mem_image[a]};
    endfunction

    // Pointers live in page zero and the high byte wraps inside it.
    function automatic logic [15:0] zp_pointer(input logic [7:0] p);
        logic [7:0] p_hi;
        p_hi = p + 8'd1;
        return {mem_image[p_hi], mem_image[p]};
    endfunction

    function automatic access_t perform_access(input logic [S_TDATA_W-1:0] beat);
        logic [1:0]  cmd;
        logic [3:0]  mode;
        logic [15:0] op;
        logic [15:0] wd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [8:0]  lo;
        logic [8:0]  hi;
        access_t     r;
        cmd  = beat[1:0];
        mode = beat[5:2];
        op   = beat[21:6];
        x    = beat[29:22];
        y    = beat[37:30];
        wd   = beat[53:38];
        r    = '0;
        if (!cmd[CMD_WORD_BIT]) begin
            case (mode)
                MODE_ZPG:  r.addr = op & ZP_MASK;
                MODE_ZPGX: r.addr = (op + x) & ZP_MASK;
                MODE_ZPGY: r.addr = (op + y) & ZP_MASK;
                MODE_ABSX: r.addr = op + x;
                MODE_ABSY: r.addr = op + y;
                MODE_IND:  r.addr = zp_pointer(op[7:0]);
                MODE_INDX: r.addr = zp_pointer(op[7:0] + x);
                MODE_INDY: r.addr = zp_pointer(op[7:0]) + y;
                default:   r.addr = op;
            endcase
            lo = touch_byte(r.addr, cmd[CMD_WRITE_BIT], wd[7:0]);
            r.data     = {8'h00, lo[7:0]};
            r.ext_mask = {1'b0, lo[8]};
        end else begin
            r.addr = op;
            lo = touch_byte(op, cmd[CMD_WRITE_BIT], wd[7:0]);
            hi = touch_byte(op + 16'd1, cmd[CMD_WRITE_BIT], wd[15:8]);
            r.data     = {hi[7:0], lo[7:0]};
            r.ext_mask = {hi[8], lo[8]};
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        access_t want;
        if (!aresetn) begin
            ram_limit_q = RAM_LIMIT_RESET;
            pending_q.delete();
            for (int i = 0; i < RAM_DEPTH; i++)
                mem_image[i] = 8'h00;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    $error("result beat with no access outstanding: m_tdata=%h", m_tdata);
                    fails++;
                end else begin
                    want = pending_q.pop_front();
                    checked++;
                    if (m_tdata[15:0] !== want.addr) begin
                        $error("effective_address: expected %h, got %h",
                               want.addr, m_tdata[15:0]);
                        fails++;
                    end
                    if (m_tdata[31:16] !== want.data) begin
                        $error("read_data: expected %h, got %h", want.data, m_tdata[31:16]);
                        fails++;
                    end
                    if (m_tdata[33:32] !== want.ext_mask) begin
                        $error("external_bytes: expected %b, got %b",
                               want.ext_mask, m_tdata[33:32]);
                        fails++;
                    end
                    if (m_tdata[M_TDATA_W-1:34] !== '0) begin
                        $error("zero fill: expected 0, got %h", m_tdata[M_TDATA_W-1:34]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(perform_access(s_tdata));
            if (cfg_valid && cfg_ready)
                ram_limit_q = cfg_data;
        end
        outstanding     <= pending_q.size();
        results_checked <= checked;
        fail_count      <= fails;
    end

endmodule

>>> sim/tb_cpu6502_operand_address_unit.sv
`timescale 1ns / 100ps

module tb_cpu6502_operand_address_unit;
    import oau_pkg::*;

    localparam logic [1:0] CMD_READ_BYTE  = 2'd0;
    localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
    localparam logic [1:0] CMD_READ_WORD  = 2'd2;
    localparam logic [1:0] CMD_WRITE_WORD = 2'd3;

    localparam logic [3:0] MODE_RESERVED_FIRST = 4'd9;
    localparam logic [3:0] MODE_RESERVED_LAST  = 4'd15;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 205;
    localparam int DRAIN_CYCLES = 8;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [LIMIT_W-1:0]     cfg_data;
    logic                   cfg_valid;
    logic                   cfg_ready;

    int outstanding;
    int results_checked;
    int fail_count;

    int cycle_count = 0;
    int burst_left = 0;
    int accesses_sent = 0;
    int limit_settings = 1;
    int limit_now = int'(RAM_LIMIT_RESET);
    bit long_hold_done = 1'b0;

    always #4 aclk = ~aclk;

    cpu6502_operand_address_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    oau_access_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_data        (cfg_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .fail_count      (fail_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver switches among random stall patterns and once holds off
    // for a long stretch so that the block backs up into its input.
    initial begin
        int style;
        m_tready <= 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(posedge aclk);
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
            if (!long_hold_done && results_checked >= 150) begin
                long_hold_done = 1'b1;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
        end
    end

    task automatic issue_access(input logic [1:0] cmd, input logic [3:0] mode,
                                input logic [15:0] op, input logic [7:0] ix,
                                input logic [7:0] iy, input logic [15:0] wd);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {2'b00, wd, iy, ix, op, mode, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        accesses_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_ram_limit(input logic [LIMIT_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = int'(value);
        limit_settings++;
    endtask

    // Addresses cluster in page zero, a small data window, around the limit and at the
    // top of memory so that later reads find earlier writes.
    function automatic logic [15:0] pick_target();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 255));
            4, 5:       return 16'h0300 + 16'($urandom_range(0, 31));
            6, 7:       return 16'(limit_now - 4 + int'($urandom_range(0, 7)));
            8:          return 16'hfff8 + 16'($urandom_range(0, 7));
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_mode();
        if ($urandom_range(0, 5) == 0)
            return 4'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST));
        return 4'($urandom_range(MODE_ZPG, MODE_INDY));
    endfunction

    task automatic run_random_phase(input int n);
        int          sent;
        logic [7:0]  p;
        logic [7:0]  ix;
        logic [7:0]  iy;
        logic [7:0]  page;
        logic [7:0]  zp_op;
        logic [3:0]  ind_mode;
        logic [15:0] target;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 4) begin
                p      = 8'($urandom);
                ix     = 8'($urandom);
                iy     = 8'($urandom);
                page   = 8'($urandom);
                target = pick_target();
                issue_access(CMD_WRITE_WORD, 4'($urandom), {8'h00, p}, ix, iy, target);
                case ($urandom_range(0, 2))
                    0: begin
                        ind_mode = MODE_IND;
                        zp_op    = p;
                    end
                    1: begin
                        ind_mode = MODE_INDX;
                        zp_op    = p - ix;
                    end
                    default: begin
                        ind_mode = MODE_INDY;
                        zp_op    = p;
                    end
                endcase
                issue_access(CMD_WRITE_BYTE, ind_mode, {page, zp_op}, ix, iy,
                             16'($urandom));
                issue_access(CMD_READ_BYTE, ind_mode, {page, zp_op}, ix, iy,
                             16'($urandom));
                issue_access(CMD_READ_WORD, pick_mode(), target, ix, iy, 16'($urandom));
                sent += 4;
            end else begin
                issue_access(2'($urandom), pick_mode(), pick_target(), 8'($urandom),
                             8'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed accesses under the reset limit.
        issue_access(CMD_READ_BYTE, MODE_ZPG, 16'h0000, 8'h00, 8'h00, 16'h0000);
        issue_access(CMD_WRITE_WORD, MODE_ABS, 16'h0010, 8'h00, 8'h00, 16'h1234);
        issue_access(CMD_WRITE_BYTE, MODE_IND, 16'h7710, 8'h00, 8'h00, 16'h00ab);
        issue_access(CMD_READ_BYTE, MODE_ABS, 16'h1234, 8'h00, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_INDX, 16'h000e, 8'h02, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_INDY, 16'h0010, 8'h00, 8'hff, 16'h0000);
        issue_access(CMD_WRITE_BYTE, MODE_ZPG, 16'h00ff, 8'h00, 8'h00, 16'h0020);
        issue_access(CMD_WRITE_BYTE, MODE_ZPG, 16'hff00, 8'h00, 8'h00, 16'hee03);
        issue_access(CMD_READ_BYTE, MODE_IND, 16'h00ff, 8'h00, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_INDX, 16'habf0, 8'h0f, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_ZPGX, 16'h0080, 8'h90, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_ZPGY, 16'h00ff, 8'h00, 8'hff, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_ABSX, 16'hffff, 8'hff, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_ABSY, 16'hfff0, 8'h00, 8'h20, 16'h0000);
        issue_access(CMD_WRITE_BYTE, MODE_ABS, 16'hc000, 8'h00, 8'h00, 16'h0055);
        issue_access(CMD_READ_BYTE, MODE_ABS, 16'hbfff, 8'h00, 8'h00, 16'h0000);
        issue_access(CMD_WRITE_WORD, MODE_ABS, 16'hbfff, 8'h00, 8'h00, 16'h5a5a);
        issue_access(CMD_READ_WORD, MODE_ABS, 16'hbfff, 8'h00, 8'h00, 16'h0000);
        issue_access(CMD_READ_BYTE, MODE_RESERVED_LAST, 16'h1234, 8'h11, 8'h22, 16'h0000);
        issue_access(CMD_WRITE_BYTE, MODE_RESERVED_FIRST, 16'h0400, 8'h33, 8'h44, 16'hffff);
        issue_access(CMD_READ_WORD, MODE_INDY, 16'h0010, 8'h00, 8'h05, 16'h0000);
        issue_access(CMD_WRITE_WORD, MODE_RESERVED_LAST, 16'hffff, 8'hff, 8'hff, 16'hffff);
        issue_access(CMD_READ_WORD, MODE_ZPG, 16'hffff, 8'h00, 8'h00, 16'h0000);

        run_random_phase(PHASE_ITEMS);
        write_ram_limit(17'h10000);
        run_random_phase(PHASE_ITEMS);
        write_ram_limit(17'd256);
        run_random_phase(PHASE_ITEMS);
        write_ram_limit(LIMIT_W'($urandom_range(257, 65535)));
        run_random_phase(PHASE_ITEMS);
        write_ram_limit(17'h0ffff);
        run_random_phase(PHASE_ITEMS);
        write_ram_limit(RAM_LIMIT_RESET);
        run_random_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Checked %0d result beats for %0d accesses under %0d RAM limit settings,",
                 results_checked, accesses_sent, limit_settings);
        $display("covering all addressing modes, page-zero and 16-bit wrap, and split words.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
